// File: hw/rtl/spd_pkg.sv
// shared constants for the segment pair distance unit
`timescale 1ns / 1ps
package spd_pkg;

  // width of the fixed point distance result
  localparam int DIST_W = 25;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // result selection codes
  localparam logic [1:0] SEL_A    = 2'd0;  // first segment is a point
  localparam logic [1:0] SEL_C    = 2'd1;  // second segment is a point
  localparam logic [1:0] SEL_ZERO = 2'd2;  // segments meet
  localparam logic [1:0] SEL_MIN  = 2'd3;  // least of four distances

  typedef logic [1:0] sel_t;

endpackage

// File: hw/rtl/spd_if.sv
// handshake channels for segment pairs and distance results
`timescale 1ns / 1ps
interface seg_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic signed [COORD_BITS-1:0] c_x;
  logic signed [COORD_BITS-1:0] c_y;
  logic signed [COORD_BITS-1:0] d_x;
  logic signed [COORD_BITS-1:0] d_y;
  modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
  modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

interface spd_out_if;
  logic                       valid;
  logic                       ready;
  logic [spd_pkg::DIST_W-1:0] distance_q8;
  logic                       intersecting;
  modport source (output valid, distance_q8, intersecting, input ready);
  modport sink   (input valid, distance_q8, intersecting, output ready);
endinterface

// File: hw/rtl/segment_pair_distance_unit.sv
// top level: minimum distance between two integer segments in the plane
// usage
//   seg carries one pair of segments AB and CD per transaction, res carries
//   floor(2^FRAC_BITS * distance) and a flag that the segments touch or cross
//   both channels move a transaction on a clock edge with valid and ready high
// timing
//   33 register stages: input, six front end stages (differences, products,
//   sums, case select, square partial products, numerator), 25 stages of the
//   root search (one result bit each), one output stage
//   one pair per cycle sustained while res takes results
// stalls
//   every stage advances when it is empty or the stage after it advances,
//   so bubbles close up while res is stalled and seg keeps taking pairs
//   until the pipeline is full; nothing is lost or repeated
// reset
//   rst clears every valid bit; payload registers are left as they are
`timescale 1ns / 1ps
module segment_pair_distance_unit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  seg_in_if.sink     seg,
  spd_out_if.source  res
);
  localparam int CB  = COORD_BITS;
  localparam int W   = CB + 1;
  localparam int NW  = 4 * W;
  localparam int DW  = 2 * W;
  localparam int RB  = spd_pkg::DIST_W;
  localparam int FE  = 6;            // front end stages
  localparam int RS  = FE + 1;       // first root stage
  localparam int NS  = RS + RB + 1;  // total stages
  localparam int LST = NS - 1;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  // stage enables, each stage moves when empty or when the next one moves
  always_comb begin
    en[LST] = !v[LST] || res.ready;
    for (int k = LST - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= seg.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign seg.ready = en[0];

  // input stage
  logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ax <= seg.a_x;
      ay <= seg.a_y;
      bx <= seg.b_x;
      by <= seg.b_y;
      cx <= seg.c_x;
      cy <= seg.c_y;
      dx <= seg.d_x;
      dy <= seg.d_y;
    end
  end

  // degenerate segment flags alongside the front end
  logic ab_same [1:FE];
  logic cd_same [1:FE];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ab_same[1] <= (ax == bx) && (ay == by);
      cd_same[1] <= (cx == dx) && (cy == dy);
    end
    for (int k = 2; k <= FE; k++) begin
      if (en[k]) begin
        ab_same[k] <= ab_same[k-1];
        cd_same[k] <= cd_same[k-1];
      end
    end
  end

  // four point to segment units: A to CD, B to CD, C to AB, D to AB
  logic [NW-1:0] num [4];
  logic [DW-1:0] den [4];
  logic [3:0]    cz, cn, on;
  logic [RB-1:0] root [4];

  logic signed [CB-1:0] pr_x [4], pr_y [4], pp_x [4], pp_y [4], pq_x [4], pq_y [4];
  assign pr_x = '{ax, bx, cx, dx};
  assign pr_y = '{ay, by, cy, dy};
  assign pp_x = '{cx, cx, ax, ax};
  assign pp_y = '{cy, cy, ay, ay};
  assign pq_x = '{dx, dx, bx, bx};
  assign pq_y = '{dy, dy, by, by};

  for (genvar i = 0; i < 4; i++) begin : g_unit
    spd_ptseg #(.CB(CB)) u_ptseg (
      .clk        (clk),
      .en         (en[FE:1]),
      .rx         (pr_x[i]),
      .ry         (pr_y[i]),
      .px         (pp_x[i]),
      .py         (pp_y[i]),
      .qx         (pq_x[i]),
      .qy         (pq_y[i]),
      .num        (num[i]),
      .den        (den[i]),
      .cross_zero (cz[i]),
      .cross_neg  (cn[i]),
      .on_seg     (on[i])
    );
    spd_root #(.NW(NW), .DW(DW), .FB(FRAC_BITS)) u_root (
      .clk (clk),
      .en  (en[RS+RB-1:RS]),
      .num (num[i]),
      .den (den[i]),
      .r   (root[i])
    );
  end

  // orientation codes: o1 from C about AB, o2 from D, o3 from A about CD, o4 from B
  logic [1:0] o1, o2, o3, o4;
  logic       meet, hit_w;
  spd_pkg::sel_t sel_w;
  assign o1 = {cz[2], cn[2]};
  assign o2 = {cz[3], cn[3]};
  assign o3 = {cz[0], cn[0]};
  assign o4 = {cz[1], cn[1]};
  assign meet = ((o1 != o2) && (o3 != o4)) || on[0] || on[1] || on[2] || on[3];

  always_comb begin
    if (ab_same[FE]) begin
      sel_w = spd_pkg::SEL_A;
      hit_w = on[0];
    end else if (cd_same[FE]) begin
      sel_w = spd_pkg::SEL_C;
      hit_w = on[2];
    end else if (meet) begin
      sel_w = spd_pkg::SEL_ZERO;
      hit_w = 1'b1;
    end else begin
      sel_w = spd_pkg::SEL_MIN;
      hit_w = 1'b0;
    end
  end

  // selection and flag travel alongside the root search
  spd_pkg::sel_t sel_q [RS:RS+RB-1];
  logic          hit_q [RS:RS+RB-1];
  always_ff @(posedge clk) begin
    if (en[RS]) begin
      sel_q[RS] <= sel_w;
      hit_q[RS] <= hit_w;
    end
    for (int k = RS + 1; k < RS + RB; k++) begin
      if (en[k]) begin
        sel_q[k] <= sel_q[k-1];
        hit_q[k] <= hit_q[k-1];
      end
    end
  end

  // output stage
  logic [RB-1:0] m01, m23, mall;
  assign m01  = (root[1] < root[0]) ? root[1] : root[0];
  assign m23  = (root[3] < root[2]) ? root[3] : root[2];
  assign mall = (m23 < m01) ? m23 : m01;

  logic [RB-1:0] dist_q;
  logic          int_q;
  always_ff @(posedge clk) begin
    if (en[LST]) begin
      unique case (sel_q[RS+RB-1])
        spd_pkg::SEL_A:    dist_q <= root[0];
        spd_pkg::SEL_C:    dist_q <= root[2];
        spd_pkg::SEL_ZERO: dist_q <= '0;
        default:           dist_q <= mall;
      endcase
      int_q <= hit_q[RS+RB-1];
    end
  end

  assign res.valid        = v[LST];
  assign res.distance_q8  = dist_q;
  assign res.intersecting = int_q;

endmodule

// File: hw/rtl/spd_ptseg.sv
// six stage front end: point to segment squared distance as a ratio, plus touch flags
`timescale 1ns / 1ps
module spd_ptseg #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic [5:0]           en,
  input  logic signed [CB-1:0] rx,
  input  logic signed [CB-1:0] ry,
  input  logic signed [CB-1:0] px,
  input  logic signed [CB-1:0] py,
  input  logic signed [CB-1:0] qx,
  input  logic signed [CB-1:0] qy,
  output logic [4*(CB+1)-1:0]  num,
  output logic [2*(CB+1)-1:0]  den,
  output logic                 cross_zero,
  output logic                 cross_neg,
  output logic                 on_seg
);
  localparam int W  = CB + 1;
  localparam int PW = 2 * W;
  localparam int MW = 2 * W;
  localparam int H  = W;
  localparam int NW = 4 * W;

  // stage 1: differences
  logic signed [W-1:0] ux, uy, wx, wy, zx, zy;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ux <= W'(qx) - W'(px);
      uy <= W'(qy) - W'(py);
      wx <= W'(rx) - W'(px);
      wy <= W'(ry) - W'(py);
      zx <= W'(rx) - W'(qx);
      zy <= W'(ry) - W'(qy);
    end
  end

  // stage 2: products and box flags
  logic signed [PW-1:0] cr1, cr2, wu1, wu2, zu1, zu2, uu1, uu2, ww1, ww2, zz1, zz2;
  logic deg2, onx2, ony2;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      cr1  <= PW'(ux) * PW'(wy);
      cr2  <= PW'(wx) * PW'(uy);
      wu1  <= PW'(wx) * PW'(ux);
      wu2  <= PW'(wy) * PW'(uy);
      zu1  <= PW'(zx) * PW'(ux);
      zu2  <= PW'(zy) * PW'(uy);
      uu1  <= PW'(ux) * PW'(ux);
      uu2  <= PW'(uy) * PW'(uy);
      ww1  <= PW'(wx) * PW'(wx);
      ww2  <= PW'(wy) * PW'(wy);
      zz1  <= PW'(zx) * PW'(zx);
      zz2  <= PW'(zy) * PW'(zy);
      deg2 <= (ux == '0) && (uy == '0);
      onx2 <= (wx == '0) || (zx == '0) || (wx[W-1] != zx[W-1]);
      ony2 <= (wy == '0) || (zy == '0) || (wy[W-1] != zy[W-1]);
    end
  end

  // stage 3: sums
  logic signed [PW:0] cross3, dwu3, dzu3;
  logic [MW-1:0] len3, dw3, dz3;
  logic deg3, onx3, ony3;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      cross3 <= (PW+1)'(cr1) - (PW+1)'(cr2);
      dwu3   <= (PW+1)'(wu1) + (PW+1)'(wu2);
      dzu3   <= (PW+1)'(zu1) + (PW+1)'(zu2);
      len3   <= MW'(uu1) + MW'(uu2);
      dw3    <= MW'(ww1) + MW'(ww2);
      dz3    <= MW'(zz1) + MW'(zz2);
      deg3   <= deg2;
      onx3   <= onx2;
      ony3   <= ony2;
    end
  end

  // stage 4: choose perpendicular foot or nearer end
  logic [MW-1:0] mag4, alt4, den4;
  logic use4, cz4, cn4, on4;
  logic inside3;
  assign inside3 = !dwu3[PW] && (dzu3[PW] || (dzu3 == '0));
  always_ff @(posedge clk) begin
    if (en[3]) begin
      mag4 <= cross3[PW] ? MW'(-cross3) : MW'(cross3);
      use4 <= !deg3 && inside3;
      alt4 <= (deg3 || (dw3 < dz3)) ? dw3 : dz3;
      den4 <= (!deg3 && inside3) ? len3 : MW'(1);
      cz4  <= (cross3 == '0);
      cn4  <= cross3[PW];
      on4  <= (cross3 == '0) && onx3 && ony3;
    end
  end

  // stage 5: partial products of the cross square
  logic [2*H-1:0] phh, phl, pll;
  logic [MW-1:0] alt5, den5;
  logic use5, cz5, cn5, on5;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      phh  <= (2*H)'(mag4[MW-1:H]) * (2*H)'(mag4[MW-1:H]);
      phl  <= (2*H)'(mag4[MW-1:H]) * (2*H)'(mag4[H-1:0]);
      pll  <= (2*H)'(mag4[H-1:0]) * (2*H)'(mag4[H-1:0]);
      alt5 <= alt4;
      den5 <= den4;
      use5 <= use4;
      cz5  <= cz4;
      cn5  <= cn4;
      on5  <= on4;
    end
  end

  // stage 6: numerator
  always_ff @(posedge clk) begin
    if (en[5]) begin
      num <= use5 ? (NW'(phh) << (2*H)) + (NW'(phl) << (H+1)) + NW'(pll) : NW'(alt5);
      den <= den5;
      cross_zero <= cz5;
      cross_neg  <= cn5;
      on_seg     <= on5;
    end
  end

endmodule

// File: hw/rtl/spd_root.sv
// pipelined bit per stage search for the largest r with r*r*den <= num*4^fb
`timescale 1ns / 1ps
module spd_root #(
  parameter int NW = 68,
  parameter int DW = 34,
  parameter int FB = 8
) (
  input  logic                       clk,
  input  logic [spd_pkg::DIST_W-1:0] en,
  input  logic [NW-1:0]              num,
  input  logic [DW-1:0]              den,
  output logic [spd_pkg::DIST_W-1:0] r
);
  localparam int RB = spd_pkg::DIST_W;
  localparam int SW = NW + 2 * FB;
  localparam int CW = (SW > 2 * RB + DW) ? SW + 1 : 2 * RB + DW + 1;

  // p holds r*r*den, q holds r*den, s the scaled numerator
  logic [CW-1:0] p_q [RB];
  logic [CW-1:0] q_q [RB];
  logic [CW-1:0] s_q [RB];
  logic [DW-1:0] d_q [RB];
  logic [RB-1:0] r_q [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam int B = RB - 1 - k;
    logic [CW-1:0] p_i, q_i, s_i, t;
    logic [DW-1:0] d_i;
    logic [RB-1:0] r_i;
    if (k == 0) begin : g_first
      assign p_i = '0;
      assign q_i = '0;
      assign s_i = CW'(num) << (2 * FB);
      assign d_i = den;
      assign r_i = '0;
    end else begin : g_next
      assign p_i = p_q[k-1];
      assign q_i = q_q[k-1];
      assign s_i = s_q[k-1];
      assign d_i = d_q[k-1];
      assign r_i = r_q[k-1];
    end
    // (r + 2^b)^2 * den
    assign t = p_i + (q_i << (B + 1)) + (CW'(d_i) << (2 * B));
    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (t <= s_i) begin
          p_q[k] <= t;
          q_q[k] <= q_i + (CW'(d_i) << B);
          r_q[k] <= r_i | (RB'(1) << B);
        end else begin
          p_q[k] <= p_i;
          q_q[k] <= q_i;
          r_q[k] <= r_i;
        end
        s_q[k] <= s_i;
        d_q[k] <= d_i;
      end
    end
  end

  assign r = r_q[RB-1];

endmodule

// File: hw/rtl/spd_checker.sv
// port level checks for the segment pair distance unit
`timescale 1ns / 1ps
module spd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [spd_pkg::DIST_W-1:0] distance_q8,
  input logic                       intersecting
);

  // stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(distance_q8) && $stable(intersecting))
    else $error("result changed while stalled");

  // touching segments report zero distance
  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && intersecting |-> distance_q8 == '0)
    else $error("intersecting with nonzero distance");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  // an empty output stage never holds back the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind segment_pair_distance_unit spd_checker u_spd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (seg.ready),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .distance_q8  (res.distance_q8),
  .intersecting (res.intersecting)
);

// File: test/tb_segment_pair_distance_unit.sv
// testbench for the segment pair distance unit: directed table, random pairs, scoreboard
`timescale 1ns / 1ps
module tb_segment_pair_distance_unit;

  localparam int CB = 16;
  localparam int FB = 8;
  localparam int N_RANDOM = 1700;
  localparam int WATCHDOG = 5000;

  typedef struct {
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  } seg_pair_t;

  typedef struct {
    logic [spd_pkg::DIST_W-1:0] dist_q8;
    logic                       hit;
  } dist_res_t;

  // one row of the directed table; chk set where the answer is typed in
  typedef struct {
    seg_pair_t p;
    bit        chk;
    dist_res_t r;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  seg_in_if  #(.COORD_BITS(CB)) seg ();
  spd_out_if                    res ();

  segment_pair_distance_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .seg(seg.sink), .res(res.source)
  );

  always #5 clk = ~clk;

  // expected distances in order of acceptance
  dist_res_t expected_q[$];
  int        fails = 0;
  int        n_seen = 0;
  int        n_hits = 0;
  bit        no_idle = 1'b0;
  bit        hold_off = 1'b0;
  int        idle_cnt = 0;

  // ---------------- predictor ----------------
  function automatic longint crs(longint ox, oy, ux, uy, vx, vy);
    return (ux - ox) * (vy - oy) - (vx - ox) * (uy - oy);
  endfunction

  function automatic longint dt(longint ox, oy, ux, uy, vx, vy);
    return (ux - ox) * (vx - ox) + (uy - oy) * (vy - oy);
  endfunction

  // largest r within the result range with r*r*den <= num * 4^FB
  function automatic logic [spd_pkg::DIST_W-1:0] root_ratio(logic [127:0] num,
                                                             logic [63:0] den);
    logic [191:0] scaled, prod;
    logic [spd_pkg::DIST_W-1:0] r, t;
    scaled = {64'd0, num} << (2 * FB);
    r = '0;
    for (int b = spd_pkg::DIST_W - 1; b >= 0; b--) begin
      t = r | (spd_pkg::DIST_W'(1) << b);
      prod = 192'(t) * 192'(t) * 192'(den);
      if (prod <= scaled) r = t;
    end
    return r;
  endfunction

  function automatic logic [spd_pkg::DIST_W-1:0] pt_pt(longint rx, ry, px, py);
    return root_ratio(128'(dt(px, py, rx, ry, rx, ry)), 64'd1);
  endfunction

  function automatic logic [spd_pkg::DIST_W-1:0] pt_seg(longint rx, ry, px, py, qx, qy);
    longint cr;
    logic [spd_pkg::DIST_W-1:0] d1, d2;
    logic [63:0] mag;
    if (px == qx && py == qy) return pt_pt(rx, ry, px, py);
    if (dt(px, py, rx, ry, qx, qy) >= 0 && dt(qx, qy, rx, ry, px, py) >= 0) begin
      cr = crs(px, py, qx, qy, rx, ry);
      mag = cr < 0 ? -cr : cr;
      return root_ratio(128'(mag) * 128'(mag), 64'(dt(px, py, qx, qy, qx, qy)));
    end
    d1 = pt_pt(rx, ry, px, py);
    d2 = pt_pt(rx, ry, qx, qy);
    return d1 < d2 ? d1 : d2;
  endfunction

  function automatic int orient(longint ax, ay, bx, by, cx, cy);
    longint v;
    v = (cx - ax) * (by - ay) - (bx - ax) * (cy - ay);
    if (v == 0) return 0;
    return v > 0 ? 1 : 2;
  endfunction

  function automatic bit on_seg(longint rx, ry, px, py, qx, qy);
    if (crs(px, py, qx, qy, rx, ry) != 0) return 1'b0;
    return rx <= (px > qx ? px : qx) && rx >= (px < qx ? px : qx) &&
           ry <= (py > qy ? py : qy) && ry >= (py < qy ? py : qy);
  endfunction

  function automatic dist_res_t predict_distance(seg_pair_t s);
    longint ax, ay, bx, by, cx, cy, dx, dy;
    int o1, o2, o3, o4;
    logic [spd_pkg::DIST_W-1:0] m, t;
    dist_res_t r;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
    if (ax == bx && ay == by) begin
      r.dist_q8 = pt_seg(ax, ay, cx, cy, dx, dy);
      r.hit = on_seg(ax, ay, cx, cy, dx, dy);
      return r;
    end
    if (cx == dx && cy == dy) begin
      r.dist_q8 = pt_seg(cx, cy, ax, ay, bx, by);
      r.hit = on_seg(cx, cy, ax, ay, bx, by);
      return r;
    end
    o1 = orient(ax, ay, bx, by, cx, cy);
    o2 = orient(ax, ay, bx, by, dx, dy);
    o3 = orient(cx, cy, dx, dy, ax, ay);
    o4 = orient(cx, cy, dx, dy, bx, by);
    if ((o1 != o2 && o3 != o4) ||
        (o1 == 0 && on_seg(cx, cy, ax, ay, bx, by)) ||
        (o2 == 0 && on_seg(dx, dy, ax, ay, bx, by)) ||
        (o3 == 0 && on_seg(ax, ay, cx, cy, dx, dy)) ||
        (o4 == 0 && on_seg(bx, by, cx, cy, dx, dy))) begin
      r.dist_q8 = '0;
      r.hit = 1'b1;
      return r;
    end
    m = pt_seg(ax, ay, cx, cy, dx, dy);
    t = pt_seg(bx, by, cx, cy, dx, dy); if (t < m) m = t;
    t = pt_seg(cx, cy, ax, ay, bx, by); if (t < m) m = t;
    t = pt_seg(dx, dy, ax, ay, bx, by); if (t < m) m = t;
    r.dist_q8 = m;
    r.hit = 1'b0;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic seg_pair_t mk(int ax, ay, bx, by, cx, cy, dx, dy);
    seg_pair_t s;
    s.ax = CB'(ax); s.ay = CB'(ay); s.bx = CB'(bx); s.by = CB'(by);
    s.cx = CB'(cx); s.cy = CB'(cy); s.dx = CB'(dx); s.dy = CB'(dy);
    return s;
  endfunction

  // coordinate: mostly small to hit touches and collinear cases, some full range
  function automatic logic signed [CB-1:0] rnd_coord(int mode);
    case (mode)
      0: return CB'($urandom_range(0, 8) - 4);
      1: return CB'($urandom_range(0, 400) - 200);
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic seg_pair_t rnd_pair();
    seg_pair_t s;
    int mode;
    mode = $urandom_range(0, 2);
    s = mk(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
           rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode));
    case ($urandom_range(0, 9))
      0: begin s.bx = s.ax; s.by = s.ay; end                 // first segment a point
      1: begin s.dx = s.cx; s.dy = s.cy; end                 // second segment a point
      2: begin s.bx = s.ax; s.by = s.ay; s.cx = s.ax; s.cy = s.ay; s.dx = s.ax; s.dy = s.ay; end
      3: begin s.cx = s.bx; s.cy = s.by; end                 // shared endpoint
      4: begin                                               // collinear second segment
        s.cx = CB'(s.ax + 2 * (s.bx - s.ax)); s.cy = CB'(s.ay + 2 * (s.by - s.ay));
        s.dx = CB'(s.ax + 3 * (s.bx - s.ax)); s.dy = CB'(s.ay + 3 * (s.by - s.ay));
      end
      default: ;
    endcase
    return s;
  endfunction

  // directed table
  stim_row_t table_rows[$];

  task automatic add_row(seg_pair_t p, bit chk, int d, bit h);
    stim_row_t row;
    row.p = p; row.chk = chk; row.r.dist_q8 = spd_pkg::DIST_W'(d); row.r.hit = h;
    table_rows = {table_rows, row};
  endtask

  task automatic build_table();
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1);                     // all zero
    add_row(mk(0, 0, 0, 0, 3, 4, 3, 4), 1, 5 * 256, 0);               // both points
    add_row(mk(0, 0, 0, 0, 1, 1, 1, 1), 1, 362, 0);                   // sqrt 2
    add_row(mk(0, 0, 4, 4, 0, 4, 4, 0), 1, 0, 1);                     // crossing
    add_row(mk(0, 0, 4, 0, 4, 0, 8, 3), 1, 0, 1);                     // shared end
    add_row(mk(0, 0, 4, 0, 2, 0, 6, 0), 1, 0, 1);                     // collinear overlap
    add_row(mk(0, 0, 4, 0, 5, 0, 9, 0), 1, 256, 0);                   // collinear gap
    add_row(mk(0, 0, 10, 0, 5, 3, 5, 9), 1, 3 * 256, 0);              // foot inside
    add_row(mk(0, 0, 10, 0, 13, 4, 20, 4), 1, 5 * 256, 0);            // foot outside
    add_row(mk(2, 0, 2, 0, 0, 0, 4, 0), 1, 0, 1);                     // point on segment
    add_row(mk(0, 0, 4, 0, 2, 0, 2, 0), 1, 0, 1);                     // point on first
    add_row(mk(0, 0, 4, 0, 6, 0, 6, 0), 1, 2 * 256, 0);               // point past end
    add_row(mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767), 0, 0, 0);
    add_row(mk(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767), 1, 0, 1);
    add_row(mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767), 1,
            65535 * 256, 0);
    add_row(mk(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768), 0, 0, 0);
    add_row(mk(-1, -1, -1, -1, 0, 0, 0, 0), 1, 362, 0);
    add_row(mk(0, 0, 1, 3, 5, 1, 7, 2), 0, 0, 0);
    add_row(mk(-32768, 0, 32767, 1, 0, -32768, 1, 32767), 0, 0, 0);
    add_row(mk(21845, -21846, -21846, 21845, 1, 1, 2, 3), 0, 0, 0);
  endtask

  // ---------------- sender ----------------
  task automatic send_pair(seg_pair_t s);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      seg.valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    seg.valid <= 1'b1;
    seg.a_x <= s.ax; seg.a_y <= s.ay; seg.b_x <= s.bx; seg.b_y <= s.by;
    seg.c_x <= s.cx; seg.c_y <= s.cy; seg.d_x <= s.dx; seg.d_y <= s.dy;
    @(posedge clk);
    while (!seg.ready) @(posedge clk);
  endtask

  // acceptance monitor: predictions are queued at the handshake edge
  always @(posedge clk) begin
    if (!rst && seg.valid && seg.ready) begin
      expected_q = {expected_q, predict_distance(mk(seg.a_x, seg.a_y, seg.b_x, seg.b_y,
                                                    seg.c_x, seg.c_y, seg.d_x, seg.d_y))};
    end
  end

  // directed rows with a typed-in answer are checked against it as well
  dist_res_t typed_q[$];
  bit        typed_chk_q[$];

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    dist_res_t e;
    bit        tchk;
    dist_res_t tv;
    if (!rst && res.valid && res.ready) begin
      n_seen++;
      if (res.intersecting) n_hits++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual dist=%0d hit=%0b",
                 $time, res.distance_q8, res.intersecting);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (res.distance_q8 !== e.dist_q8) begin
          $display("%0t distance mismatch: expected %0d, actual %0d",
                   $time, e.dist_q8, res.distance_q8);
          fails++;
        end
        if (res.intersecting !== e.hit) begin
          $display("%0t intersect mismatch: expected %0b, actual %0b",
                   $time, e.hit, res.intersecting);
          fails++;
        end
      end
      if (typed_chk_q.size() > 0) begin
        tchk = typed_chk_q.pop_front();
        tv = typed_q.pop_front();
        if (tchk && (res.distance_q8 !== tv.dist_q8 || res.intersecting !== tv.hit)) begin
          $display("%0t table mismatch: expected dist=%0d hit=%0b, actual dist=%0d hit=%0b",
                   $time, tv.dist_q8, tv.hit, res.distance_q8, res.intersecting);
          fails++;
        end
      end
    end
  end

  // ready: random stall bursts, one long hold-off, none at the end
  initial begin
    int burst;
    res.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        res.ready <= 1'b0;
        @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        burst = $urandom_range(1, 13);
        repeat (burst) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (seg.valid && seg.ready) || (res.valid && res.ready) || hold_off)
      idle_cnt <= 0;
    else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    seg.valid = 1'b0;
    {seg.a_x, seg.a_y, seg.b_x, seg.b_y, seg.c_x, seg.c_y, seg.d_x, seg.d_y} = '0;
    build_table();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) begin
      typed_chk_q = {typed_chk_q, table_rows[i].chk};
      typed_q = {typed_q, table_rows[i].r};
      send_pair(table_rows[i].p);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      // long receiver hold-off while pairs keep coming, so the pipeline fills
      if (i == 300) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (120) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (i == N_RANDOM - 200) no_idle = 1'b1;
      send_pair(rnd_pair());
    end
    seg.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d directed and %0d random pairs; %0d results, %0d touching",
             table_rows.size(), N_RANDOM, n_seen, n_hits);
    if (fails == 0 && expected_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
